>>> sv/rrsf_pkg.sv
// ----------------------------------------------------------------------------
// rrsf_pkg: shared types and constants for the report slot flusher
// Word layouts, item kinds, slot geometry and the slot index wrap helper.
// ----------------------------------------------------------------------------
package rrsf_pkg;

  localparam int SLOT_COUNT      = 8;
  localparam int KEYS_PER_REPORT = 6;
  localparam int KEY_FIELDS      = 6;
  localparam int SLOT_W          = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {
    KIND_STORE       = 2'd0,
    KIND_RELEASE_ONE = 2'd1,
    KIND_RELEASE_ALL = 2'd2,
    KIND_FLUSH       = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  report_id;
    logic [7:0]  modifier;
    logic [7:0]  keycode_0;
    logic [7:0]  keycode_1;
    logic [7:0]  keycode_2;
    logic [7:0]  keycode_3;
    logic [7:0]  keycode_4;
    logic [7:0]  keycode_5;
    logic        host_ready;
    logic        host_accepts;
  } in_word_t;

  typedef struct packed {
    logic        offered;
    logic [7:0]  out_report_id;
    logic [7:0]  out_modifier;
    logic [7:0]  out_key_0;
    logic [7:0]  out_key_1;
    logic [7:0]  out_key_2;
    logic [7:0]  out_key_3;
    logic [7:0]  out_key_4;
    logic [7:0]  out_key_5;
  } out_word_t;

  typedef struct packed {
    logic [7:0]                          modifier;
    logic [KEYS_PER_REPORT-1:0][7:0]     keys;
  } slot_rpt_t;

  // Held input word as seen by the slot bank.
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  // (a + b) mod SLOT_COUNT for a below SLOT_COUNT and b below SLOT_COUNT.
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W:0]   b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + b;
    if (sum >= (SLOT_W+1)'(SLOT_COUNT)) begin
      sum = sum - (SLOT_W+1)'(SLOT_COUNT);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

>>> sv/rrsf_in_stage.sv
// ----------------------------------------------------------------------------
// rrsf_in_stage: input word register
// Captures one word from the input channel and holds it until it advances.
// ----------------------------------------------------------------------------
module rrsf_in_stage import rrsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     advance,
  output stage_t   held
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     load;

  // Take a new word when empty or when the held one moves on this cycle.
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_data;
    end
  end

  assign held.valid = valid_r;
  assign held.word  = word_r;

endmodule

>>> sv/rrsf_slot_bank.sv
// ----------------------------------------------------------------------------
// rrsf_slot_bank: report slots, dirty marks and round-robin pick
// Applies store and release words, and builds the flush result.
// ----------------------------------------------------------------------------
module rrsf_slot_bank import rrsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  in_word_t   item,
  input  logic [7:0] base_id,
  output out_word_t  result
);

  slot_rpt_t             store_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] dirty_r;
  logic [SLOT_COUNT-1:0] dirty_nxt;
  logic [SLOT_W-1:0]     scan_r;
  logic [SLOT_W-1:0]     scan_nxt;

  logic [7:0]                 slot_off;
  logic                       in_range;
  logic [SLOT_W-1:0]          tgt;
  logic [KEY_FIELDS-1:0][7:0] in_keys;
  logic [KEY_FIELDS-1:0][7:0] shown_keys;
  slot_rpt_t                  wr_rpt;
  slot_rpt_t                  pick_rpt;
  logic                       found;
  logic [SLOT_W-1:0]          pick_idx;
  logic [SLOT_W-1:0]          cand;
  logic                       hand_over;

  assign slot_off = item.report_id - base_id;
  assign in_range = slot_off < 8'(SLOT_COUNT);
  assign tgt      = slot_off[SLOT_W-1:0];

  assign in_keys[0] = item.keycode_0;
  assign in_keys[1] = item.keycode_1;
  assign in_keys[2] = item.keycode_2;
  assign in_keys[3] = item.keycode_3;
  assign in_keys[4] = item.keycode_4;
  assign in_keys[5] = item.keycode_5;

  always_comb begin
    wr_rpt.modifier = item.modifier;
    for (int k = 0; k < KEYS_PER_REPORT; k++) begin
      wr_rpt.keys[k] = in_keys[k];
    end
  end

  // Rotating priority: first dirty slot at or after the scan pointer.
  always_comb begin
    found    = 1'b0;
    pick_idx = '0;
    cand     = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cand = slot_wrap(scan_r, (SLOT_W+1)'(i));
      if (!found && dirty_r[cand]) begin
        found    = 1'b1;
        pick_idx = cand;
      end
    end
  end

  assign pick_rpt  = store_r[pick_idx];
  assign hand_over = item.host_ready && found;

  always_comb begin
    shown_keys = '0;
    for (int k = 0; k < KEYS_PER_REPORT; k++) begin
      shown_keys[k] = pick_rpt.keys[k];
    end
    result = '0;
    if (hand_over) begin
      result.offered       = 1'b1;
      result.out_report_id = base_id + 8'(pick_idx);
      result.out_modifier  = pick_rpt.modifier;
      result.out_key_0     = shown_keys[0];
      result.out_key_1     = shown_keys[1];
      result.out_key_2     = shown_keys[2];
      result.out_key_3     = shown_keys[3];
      result.out_key_4     = shown_keys[4];
      result.out_key_5     = shown_keys[5];
    end
  end

  always_comb begin
    dirty_nxt = dirty_r;
    scan_nxt  = scan_r;
    if (go) begin
      unique case (item.kind)
        KIND_STORE, KIND_RELEASE_ONE: begin
          if (in_range) begin
            dirty_nxt[tgt] = 1'b1;
          end
        end
        KIND_RELEASE_ALL: begin
          dirty_nxt = '1;
        end
        KIND_FLUSH: begin
          if (hand_over && item.host_accepts) begin
            dirty_nxt[pick_idx] = 1'b0;
            scan_nxt            = slot_wrap(pick_idx, (SLOT_W+1)'(1));
          end
        end
        default: begin
          dirty_nxt = dirty_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
      scan_r  <= '0;
    end else begin
      dirty_r <= dirty_nxt;
      scan_r  <= scan_nxt;
    end
  end

  // Slot contents: no reset, a slot is read only after it has been marked dirty.
  always_ff @(posedge clk) begin
    if (go) begin
      unique case (item.kind)
        KIND_STORE: begin
          if (in_range) begin
            store_r[tgt] <= wr_rpt;
          end
        end
        KIND_RELEASE_ONE: begin
          if (in_range) begin
            store_r[tgt] <= '0;
          end
        end
        KIND_RELEASE_ALL: begin
          for (int s = 0; s < SLOT_COUNT; s++) begin
            store_r[s] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/rrsf_out_stage.sv
// ----------------------------------------------------------------------------
// rrsf_out_stage: result word register
// Holds one flush result until the consumer takes it.
// ----------------------------------------------------------------------------
module rrsf_out_stage import rrsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t result,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_word_t word_r;

  // Free when empty or when the held word leaves this cycle.
  assign room      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (room ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = word_r;

endmodule

>>> sv/round_robin_report_slot_flusher.sv
// ----------------------------------------------------------------------------
// round_robin_report_slot_flusher: pending report slots with round-robin flush
// Top level: input register, slot bank, result register and config register.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle while no flush word waits for the
// result register, and produces a result word only for flush words. An accepted
// word sits in the input register and is applied to the slot bank when it
// advances, which also loads a flush result into the result register, from
// which it shows on out_. Store and release words never wait on the output
// side; a flush word waits in the input register only while the result
// register is full and stalled. The bank holds SLOT_COUNT reports, a dirty
// mark per slot and a scan pointer; the pick of the next dirty slot is a
// rotating priority search done in the same cycle as the update. The base
// id register is written through cfg_ (always ready) and must only be
// changed while no words are in flight.
// ----------------------------------------------------------------------------
module round_robin_report_slot_flusher import rrsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  stage_t     held;
  out_word_t  result;
  logic       room;
  logic       advance;
  logic       flush_go;
  logic [7:0] base_id_r;

  // Hold a flush while the result register cannot take its word; advance
  // every other kind at once.
  assign advance  = held.valid && ((held.word.kind != KIND_FLUSH) || room);
  assign flush_go = advance && (held.word.kind == KIND_FLUSH);

  // Base id of slot zero; slot ids follow consecutively, wrapping at 256.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      base_id_r <= cfg_data;
    end
  end

  rrsf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .held     (held)
  );

  rrsf_slot_bank u_slot_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (advance),
    .item    (held.word),
    .base_id (base_id_r),
    .result  (result)
  );

  rrsf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (flush_go),
    .result    (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
